### src/edidvp_pkg.sv
// Package for the EDID base block checker/patcher.
// Holds the request/response payload types, the running state type and the status codes.
// No dependencies.
package edidvp_pkg;

   localparam int unsigned BLOCK_BYTES = 128;
   localparam int unsigned POS_W       = 7;

   localparam logic [POS_W-1:0] LAST_POS    = 7'(BLOCK_BYTES - 1);
   localparam logic [POS_W-1:0] EXT_CNT_POS = 7'(BLOCK_BYTES - 2);
   localparam logic [POS_W-1:0] HDR_POS_FIRST_FF = 7'd1;
   localparam logic [POS_W-1:0] HDR_POS_LAST_FF  = 7'd6;
   localparam logic [POS_W-1:0] HDR_POS_TAIL     = 7'd7;

   localparam logic [7:0] HDR_BYTE_ZERO = 8'h00;
   localparam logic [7:0] HDR_BYTE_FF   = 8'hFF;

   // check_status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_CKSUM_BAD = 3'd1;
   localparam logic [2:0] STAT_BYTE0_BAD = 3'd2;
   localparam logic [2:0] STAT_FF_BAD    = 3'd3;
   localparam logic [2:0] STAT_BYTE7_BAD = 3'd4;

   typedef struct packed {
      logic       block_start;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] byte_index;
      logic [7:0]       patched_byte;
      logic             block_done;
      logic [2:0]       check_status;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [7:0]       raw_sum;
      logic [7:0]       patched_sum;
      logic [2:0]       header_fault;
   } state_type;

endpackage

### src/edidvp_step.sv
// Per-byte step of the EDID checker/patcher: patch, running sums, header check, status.
// Pure combinational; uses edidvp_pkg types and constants.
module edidvp_step (
   input  edidvp_pkg::state_type cur_state,
   input  edidvp_pkg::req_type   req,
   output edidvp_pkg::state_type nxt_state,
   output edidvp_pkg::rsp_type   rsp
);

   edidvp_pkg::state_type eff;
   logic [7:0]            patched;
   logic [2:0]            fault;
   logic [2:0]            hdr_fault;
   logic [7:0]            new_raw;
   logic                  done;

   always_comb begin
      // start flag restarts the block on this byte
      if (req.block_start) begin
         eff = '0;
      end else begin
         eff = cur_state;
      end

      if (eff.position == edidvp_pkg::EXT_CNT_POS) begin
         patched = 8'h00;
      end else if (eff.position == edidvp_pkg::LAST_POS) begin
         patched = 8'h00 - eff.patched_sum;
      end else begin
         patched = req.byte_value;
      end

      fault = edidvp_pkg::STAT_OK;
      if (eff.position == '0) begin
         if (req.byte_value != edidvp_pkg::HDR_BYTE_ZERO) fault = edidvp_pkg::STAT_BYTE0_BAD;
      end else if (eff.position >= edidvp_pkg::HDR_POS_FIRST_FF &&
                   eff.position <= edidvp_pkg::HDR_POS_LAST_FF) begin
         if (req.byte_value != edidvp_pkg::HDR_BYTE_FF) fault = edidvp_pkg::STAT_FF_BAD;
      end else if (eff.position == edidvp_pkg::HDR_POS_TAIL) begin
         if (req.byte_value != edidvp_pkg::HDR_BYTE_ZERO) fault = edidvp_pkg::STAT_BYTE7_BAD;
      end

      // first fault seen sticks
      hdr_fault = (eff.header_fault == edidvp_pkg::STAT_OK) ? fault : eff.header_fault;
      new_raw   = eff.raw_sum + req.byte_value;
      done      = (eff.position == edidvp_pkg::LAST_POS);

      rsp.byte_index   = eff.position;
      rsp.patched_byte = patched;
      rsp.block_done   = done;
      if (!done) begin
         rsp.check_status = edidvp_pkg::STAT_OK;
      end else if (new_raw != 8'h00) begin
         rsp.check_status = edidvp_pkg::STAT_CKSUM_BAD;
      end else begin
         rsp.check_status = hdr_fault;
      end

      if (done) begin
         nxt_state = '0;
      end else begin
         nxt_state.position     = eff.position + 7'd1;
         nxt_state.raw_sum      = new_raw;
         nxt_state.patched_sum  = eff.patched_sum + patched;
         nxt_state.header_fault = hdr_fault;
      end
   end

endmodule

### src/edid_block_validate_and_patch.sv
// Top level of the EDID base block checker/patcher: state registers and output register.
// Depends on edidvp_pkg and edidvp_step.
//
//   port group   dir   payload                       handshake
//   req_*        in    edidvp_pkg::req_type          req_valid / req_stall
//   rsp_*        out   edidvp_pkg::rsp_type          rsp_valid / rsp_stall
//
// One request per cycle while req_stall is low; each request gives its response in the cycle after acceptance.
// The running sums and header fault live in one register set updated on every accepted byte.
// Reset clears the position, sums, fault and the response valid flag; no clearing pass.
// req_stall is high only while a response is held and rsp_stall is high.
module edid_block_validate_and_patch (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  edidvp_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output edidvp_pkg::rsp_type rsp_data
);

   edidvp_pkg::state_type state_ff, state_in;
   edidvp_pkg::rsp_type   rsp_data_ff, step_rsp;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;

   edidvp_step u_step (
      .cur_state (state_ff),
      .req       (req_data),
      .nxt_state (state_in),
      .rsp       (step_rsp)
   );

   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= step_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_status_only_when_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.block_done |-> rsp_data_ff.check_status == edidvp_pkg::STAT_OK)
      else $error("status set on a byte that does not end the block");

   a_done_at_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.block_done == (rsp_data_ff.byte_index == edidvp_pkg::LAST_POS))
      else $error("block_done does not match the last byte position");

   a_wrap_after_done: assert property (@(posedge clock) disable iff (reset)
      accept && step_rsp.block_done |=> state_ff == '0)
      else $error("state not cleared after the last byte");

   a_start_is_byte0: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.block_start |=> rsp_data_ff.byte_index == '0)
      else $error("start flag did not resync the byte counter");

endmodule
